@@ rtl/ray_box_slab_intersection_core_macros.svh @@
// ---------------------------------------------------------------------------
// ray_box_slab_intersection_core_macros
// Assertion macros for the ray/box slab test RTL.
// ---------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECTION_CORE_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECTION_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RBSI_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RBSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rbsi_pkg.sv @@
// ---------------------------------------------------------------------------
// rbsi_pkg
// Types and constants of the ray/box slab test pipeline.
// ---------------------------------------------------------------------------
package rbsi_pkg;

    localparam int AXES  = 3;
    localparam int LANES = 2 * AXES;
    localparam int QBITS = 32;

    localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;

    // one division in flight: partial remainder, dividend bits / quotient bits
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] acc;
        logic [31:0] den;
        logic        neg;
        logic        ovf;
    } lane_t;

    // lanes 2a and 2a+1 hold the low and high slab planes of axis a
    typedef struct packed {
        lane_t [LANES-1:0] lane;
        logic  [AXES-1:0]  zdir;
        logic              zmiss;
    } item_t;

endpackage

@@ rtl/rbsi_prep.sv @@
// ---------------------------------------------------------------------------
// rbsi_prep
// Two stages: relative origin and divisor magnitude, then the six scaled
// numerators, their signs, overflow check and first partial remainders.
// ---------------------------------------------------------------------------
module rbsi_prep
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [AXES-1:0][31:0]        center,
    input  logic [AXES-1:0][30:0]        half,
    input  logic [AXES-1:0][31:0]        orig,
    input  logic [AXES-1:0][31:0]        dir,
    output logic                         out_vld,
    output item_t                        out_item
);

    localparam int NW = 34 + FRAC_BITS;
    localparam int HW = NW - 32;

    logic                    vld1_reg;
    logic [AXES-1:0][32:0]   p_reg;
    logic [AXES-1:0][30:0]   h_reg;
    logic [AXES-1:0][31:0]   dmag_reg;
    logic [AXES-1:0]         dneg_reg;
    logic [AXES-1:0]         dzero_reg;
    logic [AXES-1:0][32:0]   p_next;
    logic [AXES-1:0][31:0]   dmag_next;

    logic                    vld2_reg;
    item_t                   item_reg;
    item_t                   item_next;

    // stage one: origin relative to center, divisor magnitude
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            p_next[a]    = {orig[a][31], orig[a]} - {center[a][31], center[a]};
            dmag_next[a] = dir[a][31] ? (32'd0 - dir[a]) : dir[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_next;
            h_reg     <= half;
            dmag_reg  <= dmag_next;
            for (int a = 0; a < AXES; a++)
            begin
                dneg_reg[a]  <= dir[a][31];
                dzero_reg[a] <= (dir[a] == 32'd0);
            end
        end
    end

    // stage two: numerators, magnitudes, overflow and start remainder
    always_comb
    begin
        logic signed [33:0] hs;
        logic signed [33:0] ps;
        logic signed [33:0] num;
        logic [33:0]        mag;
        logic [NW-1:0]      full;
        logic [HW-1:0]      hi;
        logic               ovf;
        hs = '0;
        ps = '0;
        num = '0;
        mag = '0;
        full = '0;
        hi = '0;
        ovf = 1'b0;
        item_next = '0;
        for (int a = 0; a < AXES; a++)
        begin
            hs = $signed({3'b000, h_reg[a]});
            ps = $signed({p_reg[a][32], p_reg[a]});
            item_next.zdir[a] = dzero_reg[a];
            if (dzero_reg[a] && ((ps < -hs) || (ps > hs)))
            begin
                item_next.zmiss = 1'b1;
            end
            for (int s = 0; s < 2; s++)
            begin
                num  = (s == 0) ? (-hs - ps) : (hs - ps);
                mag  = num[33] ? (34'd0 - num) : num;
                full = {mag, {FRAC_BITS{1'b0}}};
                hi   = full[NW-1:32];
                ovf  = (32'(hi) >= dmag_reg[a]);
                item_next.lane[2*a+s].rem = ovf ? 32'd0 : 32'(hi);
                item_next.lane[2*a+s].acc = full[31:0];
                item_next.lane[2*a+s].den = dmag_reg[a];
                item_next.lane[2*a+s].neg = num[33] ^ dneg_reg[a];
                item_next.lane[2*a+s].ovf = ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld2_reg;
    assign out_item = item_reg;

endmodule

@@ rtl/rbsi_div_cell.sv @@
// ---------------------------------------------------------------------------
// rbsi_div_cell
// One restoring division step for all six lanes; one quotient bit per cell.
// ---------------------------------------------------------------------------
module rbsi_div_cell
    import rbsi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_vld,
    input  item_t in_item,
    output logic  out_vld,
    output item_t out_item
);

    logic  vld_reg;
    item_t item_reg;
    item_t item_next;

    // shift in next dividend bit, trial subtract, shift in quotient bit
    always_comb
    begin
        logic [32:0] sh;
        logic [32:0] diff;
        logic        ge;
        sh = '0;
        diff = '0;
        ge = 1'b0;
        item_next = in_item;
        for (int l = 0; l < LANES; l++)
        begin
            sh   = {in_item.lane[l].rem, in_item.lane[l].acc[31]};
            diff = sh - {1'b0, in_item.lane[l].den};
            ge   = (sh >= {1'b0, in_item.lane[l].den});
            item_next.lane[l].rem = ge ? diff[31:0] : sh[31:0];
            item_next.lane[l].acc = {in_item.lane[l].acc[30:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

@@ rtl/rbsi_finish.sv @@
// ---------------------------------------------------------------------------
// rbsi_finish
// Saturates and orders each slab pair, then narrows the interval and
// registers the result word.
// ---------------------------------------------------------------------------
module rbsi_finish
    import rbsi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  item_t              in_item,
    output logic               out_vld,
    output logic               out_hit,
    output logic signed [31:0] out_tmin,
    output logic signed [31:0] out_tmax
);

    logic                              vld1_reg;
    logic [AXES-1:0]                   zdir_reg;
    logic                              zmiss_reg;
    logic signed [AXES-1:0][31:0]      lo_reg;
    logic signed [AXES-1:0][31:0]      hi_reg;
    logic signed [AXES-1:0][31:0]      lo_next;
    logic signed [AXES-1:0][31:0]      hi_next;

    logic                              vld2_reg;
    logic                              hit_reg;
    logic signed [31:0]                tmin_reg;
    logic signed [31:0]                tmax_reg;
    logic                              hit_next;
    logic signed [31:0]                tmin_next;
    logic signed [31:0]                tmax_next;

    // clamp quotient magnitude and apply sign
    function automatic logic signed [31:0] sat_q(input lane_t ln);
        logic big;
        big = ln.ovf | ln.acc[31];
        if (ln.neg)
        begin
            sat_q = big ? T_MIN : $signed(32'd0 - ln.acc);
        end
        else
        begin
            sat_q = big ? T_MAX : $signed(ln.acc);
        end
    endfunction

    // stage one: saturate and order each pair
    always_comb
    begin
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        t1 = '0;
        t2 = '0;
        for (int a = 0; a < AXES; a++)
        begin
            t1 = sat_q(in_item.lane[2*a]);
            t2 = sat_q(in_item.lane[2*a+1]);
            lo_next[a] = (t1 > t2) ? t2 : t1;
            hi_next[a] = (t1 > t2) ? t1 : t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            zdir_reg  <= in_item.zdir;
            zmiss_reg <= in_item.zmiss;
        end
    end

    // stage two: narrow the interval over axes with a nonzero direction
    always_comb
    begin
        logic signed [31:0] tmin;
        logic signed [31:0] tmax;
        tmin = T_MIN;
        tmax = T_MAX;
        for (int a = 0; a < AXES; a++)
        begin
            if (!zdir_reg[a])
            begin
                // element selects of a packed array are unsigned
                if ($signed(lo_reg[a]) > tmin)
                begin
                    tmin = lo_reg[a];
                end
                if ($signed(hi_reg[a]) < tmax)
                begin
                    tmax = hi_reg[a];
                end
            end
        end
        hit_next  = !(zmiss_reg || (tmin > tmax));
        tmin_next = hit_next ? tmin : 32'sd0;
        tmax_next = hit_next ? tmax : 32'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
        end
    end

    assign out_vld  = vld2_reg;
    assign out_hit  = hit_reg;
    assign out_tmin = tmin_reg;
    assign out_tmax = tmax_reg;

endmodule

@@ rtl/ray_box_slab_intersection_core.sv @@
// Pipeline: 2 prep stages, 32 divide cells, 2 finish stages from input word to result word.
// Throughput: one word per cycle unless stalled; six quotients run side by side in each divide cell.
// The whole pipeline holds while a finished result word waits; in_ready then drops.
// Reset: rst_n asynchronous, active low, clears all stage valid bits.
// ---------------------------------------------------------------------------
// ray_box_slab_intersection_core
// Ray versus axis-aligned box slab test in signed fixed point, pipelined.
// ---------------------------------------------------------------------------
`include "ray_box_slab_intersection_core_macros.svh"

module ray_box_slab_intersection_core
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] box_center_x,
    input  logic signed [31:0] box_center_y,
    input  logic signed [31:0] box_center_z,
    input  logic [30:0]        half_size_x,
    input  logic [30:0]        half_size_y,
    input  logic [30:0]        half_size_z,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic signed [31:0] t_enter,
    output logic signed [31:0] t_exit
);

    logic                      en;
    logic [AXES-1:0][31:0]     center;
    logic [AXES-1:0][30:0]     half;
    logic [AXES-1:0][31:0]     orig;
    logic [AXES-1:0][31:0]     dir;
    logic [QBITS:0]            chain_vld;
    item_t [QBITS:0]           chain_item;

    // pipeline advances unless a result word is held
    assign en       = !(out_valid && !out_ready);
    assign in_ready = en;

    assign center = {box_center_z, box_center_y, box_center_x};
    assign half   = {half_size_z, half_size_y, half_size_x};
    assign orig   = {origin_z, origin_y, origin_x};
    assign dir    = {dir_z, dir_y, dir_x};

    // numerator and divisor setup
    rbsi_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .center   (center),
        .half     (half),
        .orig     (orig),
        .dir      (dir),
        .out_vld  (chain_vld[0]),
        .out_item (chain_item[0])
    );

    // divide chain, one quotient bit per cell
    for (genvar i = 0; i < QBITS; i++)
    begin : g_cell
        rbsi_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (chain_vld[i]),
            .in_item  (chain_item[i]),
            .out_vld  (chain_vld[i+1]),
            .out_item (chain_item[i+1])
        );
    end

    // saturation, ordering, interval narrowing
    rbsi_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (chain_vld[QBITS]),
        .in_item  (chain_item[QBITS]),
        .out_vld  (out_valid),
        .out_hit  (hit),
        .out_tmin (t_enter),
        .out_tmax (t_exit)
    );

    // result and stall checks
    `RBSI_ASSERT_IMPLY(a_miss_zero, out_valid && !hit, (t_enter == 32'sd0) && (t_exit == 32'sd0), "miss word with nonzero t")
    `RBSI_ASSERT_IMPLY(a_hit_order, out_valid && hit, t_enter <= t_exit, "hit word with t_enter above t_exit")
    `RBSI_ASSERT_IMPLY(a_stall_cause, !in_ready, out_valid && !out_ready, "input held without a blocked result word")
    `RBSI_ASSERT_NEXT(a_held_word, out_valid && !out_ready, out_valid, "result word dropped while stalled")

endmodule

@@ tb/ray_box_slab_intersection_core_tb.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_core_tb
// Self-checking bench for the ray/box slab test pipeline. A driver and a
// monitor run as clocked processes. Every word sent is also run through a
// fixed-point slab predictor, and each result word is checked in order.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int PIPE_LAT = 36;
    localparam longint T_LO = -64'sd2147483648;
    localparam longint T_HI = 64'sd2147483647;

    typedef struct {
        logic signed [31:0] ctr [3];
        logic [30:0]        half [3];
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
    } ray_box_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] t_enter;
        logic signed [31:0] t_exit;
    } slab_hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] box_center_x = '0, box_center_y = '0, box_center_z = '0;
    logic [30:0] half_size_x = '0, half_size_y = '0, half_size_z = '0;
    logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    logic signed [31:0] t_enter, t_exit;

    ray_box_t  pending_words [$];
    slab_hit_t expected_hits [$];
    int sent_count = 0;
    int checked_count = 0;
    int hit_count = 0;
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit recv_hold = 1'b0;

    ray_box_slab_intersection_core #(.FRAC_BITS(FRAC)) u_dut (.*);

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // slab parameter: exact scaled quotient toward zero, then saturated
    function automatic longint slab_t(longint num, longint d);
        logic signed [127:0] q;
        q = (128'(signed'(num)) <<< FRAC) / 128'(signed'(d));
        if (q < T_LO) return T_LO;
        if (q > T_HI) return T_HI;
        return longint'(q);
    endfunction

    function automatic slab_hit_t predict_slab_hit(ray_box_t w);
        slab_hit_t r;
        longint tmin, tmax, p, h, d, t1, t2, s;
        bit miss;
        tmin = T_LO;
        tmax = T_HI;
        miss = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            h = longint'(w.half[a]);
            p = longint'(w.org[a]) - longint'(w.ctr[a]);
            d = longint'(w.dir[a]);
            if (d == 0)
            begin
                if (p < -h || p > h) miss = 1'b1;
            end
            else
            begin
                t1 = slab_t(-h - p, d);
                t2 = slab_t(h - p, d);
                if (t1 > t2)
                begin
                    s = t1; t1 = t2; t2 = s;
                end
                if (t1 > tmin) tmin = t1;
                if (t2 < tmax) tmax = t2;
                if (tmin > tmax) miss = 1'b1;
            end
        end
        r.hit = !miss;
        r.t_enter = miss ? 32'sd0 : 32'(tmin);
        r.t_exit  = miss ? 32'sd0 : 32'(tmax);
        return r;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(0, 200 << FRAC)) - (100 << FRAC));
        endcase
    endfunction

    // mostly rays aimed at a nearby box, some pure noise
    function automatic ray_box_t rand_word();
        ray_box_t w;
        bit aimed;
        aimed = $urandom_range(0, 99) < 70;
        for (int a = 0; a < 3; a++)
        begin
            if (aimed)
            begin
                w.ctr[a]  = 32'($signed($urandom_range(0, 20 << FRAC)) - (10 << FRAC));
                w.half[a] = 31'($urandom_range(0, 4 << FRAC));
                w.org[a]  = 32'($signed($urandom_range(0, 40 << FRAC)) - (20 << FRAC));
                w.dir[a]  = $urandom_range(0, 9) == 0 ? 32'sd0 :
                            32'($signed($urandom_range(0, 4 << FRAC)) - (2 << FRAC));
            end
            else
            begin
                w.ctr[a]  = rand_q();
                w.half[a] = $urandom_range(0, 3) == 0 ? 31'h7FFF_FFFF : 31'(rand_q());
                w.org[a]  = rand_q();
                w.dir[a]  = $urandom_range(0, 5) == 0 ? 32'sd0 : rand_q();
            end
        end
        return w;
    endfunction

    function automatic ray_box_t make_word(logic signed [31:0] c, logic [30:0] h,
                                           logic signed [31:0] o, logic signed [31:0] d);
        ray_box_t w;
        for (int a = 0; a < 3; a++)
        begin
            w.ctr[a] = c; w.half[a] = h; w.org[a] = o; w.dir[a] = d;
        end
        return w;
    endfunction

    // driver: offers pending words, random idle per phase
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sent_count <= sent_count + 1;
        end
        if (!in_valid || in_ready)
        begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                ray_box_t w;
                w = pending_words.pop_front();
                expected_hits.push_back(predict_slab_hit(w));
                in_valid <= 1'b1;
                box_center_x <= w.ctr[0]; box_center_y <= w.ctr[1]; box_center_z <= w.ctr[2];
                half_size_x <= w.half[0]; half_size_y <= w.half[1]; half_size_z <= w.half[2];
                origin_x <= w.org[0]; origin_y <= w.org[1]; origin_z <= w.org[2];
                dir_x <= w.dir[0]; dir_y <= w.dir[1]; dir_z <= w.dir[2];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver ready
    always @(posedge clk)
    begin
        out_ready <= rst_n && !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: compare each result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            slab_hit_t e;
            if (expected_hits.size() == 0)
            begin
                error_count <= error_count + 1;
                if (error_count < 10)
                    $display("unexpected result word: hit=%0b t_enter=%0d t_exit=%0d",
                             hit, t_enter, t_exit);
            end
            else
            begin
                e = expected_hits.pop_front();
                checked_count <= checked_count + 1;
                if (hit) hit_count <= hit_count + 1;
                if (hit !== e.hit || t_enter !== e.t_enter || t_exit !== e.t_exit)
                begin
                    error_count <= error_count + 1;
                    if (error_count < 10)
                        $display("mismatch word %0d: exp hit=%0b te=%0d tx=%0d, got %0b %0d %0d",
                                 checked_count, e.hit, e.t_enter, e.t_exit,
                                 hit, t_enter, t_exit);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_hits.size() > 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
            pending_words.push_back(rand_word());
        wait_drained();
    endtask

    // stimulus
    initial
    begin
        logic signed [31:0] one;
        one = 32'sd1 <<< FRAC;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: hit, miss, zero direction in/out, extremes, saturation
        pending_words.push_back(make_word(0, 31'(one), -(4 * one), one));
        pending_words.push_back(make_word(0, 31'(one), -(4 * one), -one));
        pending_words.push_back(make_word(0, 31'(one), 0, 0));
        pending_words.push_back(make_word(0, 31'(one), 2 * one, 0));
        pending_words.push_back(make_word(0, 31'(one), one, 0));
        pending_words.push_back(make_word(0, 0, 0, one));
        pending_words.push_back(make_word(0, 31'h7FFF_FFFF, 32'h8000_0000, 1));
        pending_words.push_back(make_word(32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, -1));
        pending_words.push_back(make_word(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000));
        pending_words.push_back(make_word(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF));
        pending_words.push_back(make_word(-1, 31'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        pending_words.push_back(make_word(32'h5555_5555, 31'h2AAA_AAAA, 0, 32'hAAAA_AAAA));
        begin
            ray_box_t w;
            // empty interval only after a later axis
            w = make_word(0, 31'(one), -(4 * one), one);
            w.org[1] = 4 * one; w.org[0] = -(10 * one);
            pending_words.push_back(w);
            // one axis flat and outside, others hit
            w = make_word(0, 31'(one), -(4 * one), one);
            w.dir[2] = 0; w.org[2] = 3 * one;
            pending_words.push_back(w);
            // partial overlap of two slabs, one flat axis inside the box
            w = make_word(0, 31'(one), -(2 * one), one);
            w.org[1] = -one; w.dir[1] = one; w.org[1] = -(3 * one);
            w.org[2] = 0; w.dir[2] = 0;
            pending_words.push_back(w);
        end
        wait_drained();

        run_phase(400, 0, 0);
        run_phase(300, 59, 0);
        run_phase(300, 0, 59);
        run_phase(300, 17, 17);

        // receiver holds off while the sender keeps offering, to back up the pipe
        recv_hold = 1'b1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 120; i++)
            pending_words.push_back(rand_word());
        repeat (200) @(posedge clk);
        recv_hold = 1'b0;
        wait_drained();

        run_phase(330, 30, 30);
        repeat (PIPE_LAT + 10) @(posedge clk);

        $display("checked %0d result words from %0d rays (%0d hits)",
                 checked_count, sent_count, hit_count);
        $display("phases: free flow, idle sender, stalled receiver, mixed, full backup");
        if (error_count == 0 && expected_hits.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
